[design/atnp_pkg.sv]
// ----------------------------------------------------------------------------
// atnp_pkg
// Shared types, constants and helpers for the ABI type name parser.
// ----------------------------------------------------------------------------
package atnp_pkg;

    localparam int NUM_WIDTH = 16;
    localparam int TOTAL_WIDTH = NUM_WIDTH - 1;
    localparam logic [NUM_WIDTH-1:0] NUM_MAX = '1;

    localparam logic [NUM_WIDTH:0] MAX_TYPE_BITS = (NUM_WIDTH + 1)'(256);
    localparam logic [NUM_WIDTH-1:0] ADDRESS_BITS = NUM_WIDTH'(160);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    localparam int NUM_KEYWORDS = 8;

    // keyword text, first character in the lowest byte
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'h0000_0000_746E_6975,  // uint
        64'h0000_0000_0074_6E69,  // int
        64'h0073_7365_7264_6461,  // address
        64'h0000_0000_6C6F_6F62,  // bool
        64'h0000_0064_6578_6966,  // fixed
        64'h0000_6465_7869_6675,  // ufixed
        64'h0000_0073_6574_7962,  // bytes
        64'h0000_676E_6972_7473   // string
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd4, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6, 4'd5, 4'd6
    };

    typedef enum logic [2:0] {
        PH_KEYWORD = 3'd0,
        PH_WHOLE   = 3'd1,
        PH_DEC     = 3'd2,
        PH_LEN     = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERR     = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        TC_NONE    = 4'd0,
        TC_UINT    = 4'd1,
        TC_INT     = 4'd2,
        TC_ADDRESS = 4'd3,
        TC_BOOL    = 4'd4,
        TC_FIXED   = 4'd5,
        TC_UFIXED  = 4'd6,
        TC_BYTES   = 4'd7,
        TC_STRING  = 4'd8
    } type_code_t;

    // parser state captured on the last character of a name
    typedef struct packed {
        type_code_t           type_code;
        logic [NUM_WIDTH-1:0] whole;
        logic [NUM_WIDTH-1:0] dec;
        logic [NUM_WIDTH-1:0] len;
        logic                 is_list;
        logic                 syntax_ok;
    } snap_t;

    typedef struct packed {
        type_code_t             type_code;
        logic [NUM_WIDTH-1:0]   whole_bits;
        logic [NUM_WIDTH-1:0]   decimal_bits;
        logic [NUM_WIDTH-1:0]   list_length;
        logic                   is_list;
        logic                   is_dynamic;
        logic [TOTAL_WIDTH-1:0] total_bytes;
        logic                   type_valid;
    } result_t;

    // acc * 10 + d, saturating
    function automatic logic [NUM_WIDTH-1:0] add_digit(
        input logic [NUM_WIDTH-1:0] acc,
        input logic [3:0]           d
    );
        logic [NUM_WIDTH+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (NUM_WIDTH + 4)'(d);
        return (|v[NUM_WIDTH+3:NUM_WIDTH]) ? NUM_MAX : v[NUM_WIDTH-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[design/atnp_scanner.sv]
// ----------------------------------------------------------------------------
// atnp_scanner
// Character scanner: keyword match, number accumulation and grammar tracking,
// with a snapshot register loaded on the last character of each name.
// ----------------------------------------------------------------------------
module atnp_scanner
    import atnp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_data,
    input  logic       char_last,
    output logic       snap_valid,
    input  logic       snap_take,
    output snap_t      snap
);

    phase_t               phase_reg, phase_next;
    logic [7:0]           live_reg, live_next;
    logic [2:0]           idx_reg, idx_next;
    logic [NUM_WIDTH-1:0] whole_reg, whole_next;
    logic [NUM_WIDTH-1:0] dec_reg, dec_next;
    logic [NUM_WIDTH-1:0] len_reg, len_next;
    logic [1:0]           seen_reg, seen_next;
    logic                 err_reg, err_next;

    logic                 snap_valid_reg, snap_valid_next;
    snap_t                snap_reg, snap_next;

    logic [7:0]           kw_match;
    logic [7:0]           kw_hit;
    logic                 accept;
    logic                 name_end;

    assign char_ready = !snap_valid_reg || snap_take;
    assign accept     = char_valid && char_ready;
    assign name_end   = accept && char_last;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw_match[k] = live_reg[k] && ({1'b0, idx_reg} < KW_LEN[k])
                && (KW_TEXT[k][{idx_reg, 3'b000} +: 8] == char_data);
            kw_hit[k] = kw_match[k] && (({1'b0, idx_reg} + 4'd1) == KW_LEN[k]);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        live_next  = live_reg;
        idx_next   = idx_reg;
        whole_next = whole_reg;
        dec_next   = dec_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        case (phase_reg)
            PH_KEYWORD: begin
                idx_next = idx_reg + 3'd1;
                if (|kw_hit) begin
                    live_next  = kw_hit;
                    phase_next = PH_WHOLE;
                end else begin
                    live_next = kw_match;
                    if (kw_match == 8'd0) begin
                        phase_next = PH_ERR;
                        err_next   = 1'b1;
                    end
                end
            end
            PH_WHOLE: begin
                if (is_digit(char_data)) begin
                    whole_next = add_digit(whole_reg, char_data[3:0]);
                end else if (char_data == CH_X) begin
                    phase_next = PH_DEC;
                end else if (char_data == CH_LBRACKET) begin
                    phase_next = PH_LEN;
                end else begin
                    phase_next = PH_ERR;
                    err_next   = 1'b1;
                end
            end
            PH_DEC: begin
                if (is_digit(char_data)) begin
                    dec_next     = add_digit(dec_reg, char_data[3:0]);
                    seen_next[0] = 1'b1;
                end else begin
                    if (!seen_reg[0]) begin
                        err_next = 1'b1;
                    end
                    if (char_data == CH_LBRACKET) begin
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_ERR;
                        err_next   = 1'b1;
                    end
                end
            end
            PH_LEN: begin
                if (is_digit(char_data)) begin
                    len_next = add_digit(len_reg, char_data[3:0]);
                end else if (char_data == CH_RBRACKET) begin
                    seen_next[1] = 1'b1;
                    phase_next   = PH_DONE;
                end else begin
                    phase_next = PH_ERR;
                    err_next   = 1'b1;
                end
            end
            PH_DONE: begin
                phase_next = PH_ERR;
                err_next   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // snapshot of the state left by the last character
    always_comb begin
        snap_next           = snap_reg;
        snap_next.type_code = TC_NONE;
        if (phase_next != PH_KEYWORD) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (live_next == (8'd1 << k)) begin
                    snap_next.type_code = type_code_t'(4'(k + 1));
                end
            end
        end
        snap_next.whole   = whole_next;
        snap_next.dec     = dec_next;
        snap_next.len     = len_next;
        snap_next.is_list = seen_next[1];
        snap_next.syntax_ok = !err_next && (snap_next.type_code != TC_NONE)
            && (phase_next != PH_KEYWORD) && (phase_next != PH_ERR)
            && (phase_next != PH_LEN) && !((phase_next == PH_DEC) && !seen_next[0]);
    end

    always_comb begin
        snap_valid_next = snap_valid_reg;
        if (name_end) begin
            snap_valid_next = 1'b1;
        end else if (snap_take) begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_KEYWORD;
            live_reg       <= 8'hFF;
            idx_reg        <= 3'd0;
            whole_reg      <= '0;
            dec_reg        <= '0;
            len_reg        <= '0;
            seen_reg       <= 2'b00;
            err_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            if (name_end) begin
                phase_reg <= PH_KEYWORD;
                live_reg  <= 8'hFF;
                idx_reg   <= 3'd0;
                whole_reg <= '0;
                dec_reg   <= '0;
                len_reg   <= '0;
                seen_reg  <= 2'b00;
                err_reg   <= 1'b0;
            end else if (accept) begin
                phase_reg <= phase_next;
                live_reg  <= live_next;
                idx_reg   <= idx_next;
                whole_reg <= whole_next;
                dec_reg   <= dec_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (name_end) begin
            snap_reg <= snap_next;
        end
    end

    a_restart_after_name: assert property (@(posedge aclk) disable iff (!aresetn)
        name_end |=> (phase_reg == PH_KEYWORD) && (idx_reg == 3'd0) && (live_reg == 8'hFF))
        else $error("parser not restarted after last character");

    a_single_keyword: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_KEYWORD) |-> $countones(live_reg) <= 1)
        else $error("more than one keyword live after keyword phase");

    a_snap_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !snap_take) |=> snap_valid_reg && $stable(snap_reg))
        else $error("snapshot lost while waiting");

endmodule

[design/atnp_checker.sv]
// ----------------------------------------------------------------------------
// atnp_checker
// Per-type rule checks and size arithmetic on a captured name, with the
// result register that drives the output stream.
// ----------------------------------------------------------------------------
module atnp_checker
    import atnp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    snap_valid,
    output logic    snap_take,
    input  snap_t   snap,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic                 load;
    logic                 ok;
    logic [NUM_WIDTH-1:0] whole;
    logic [NUM_WIDTH-1:0] bytes_bits;
    logic [NUM_WIDTH:0]   frac_sum;
    logic [NUM_WIDTH+1:0] bit_sum;

    assign load      = !res_valid_reg || res_ready;
    assign snap_take = snap_valid && load;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign bytes_bits = (|snap.whole[NUM_WIDTH-1:NUM_WIDTH-3]) ? NUM_MAX
                                                               : {snap.whole[NUM_WIDTH-4:0], 3'b000};
    assign frac_sum = {1'b0, snap.whole} + {1'b0, snap.dec};

    always_comb begin
        ok    = snap.syntax_ok;
        whole = snap.whole;
        if (snap.syntax_ok) begin
            case (snap.type_code)
                TC_UINT, TC_INT: begin
                    ok = (snap.whole != '0) && ({1'b0, snap.whole} <= MAX_TYPE_BITS)
                        && (snap.whole[2:0] == 3'd0) && (snap.dec == '0);
                end
                TC_ADDRESS: begin
                    ok = (snap.whole == '0) && (snap.dec == '0);
                    if (ok) begin
                        whole = ADDRESS_BITS;
                    end
                end
                TC_FIXED, TC_UFIXED: begin
                    ok = (snap.whole != '0) && (snap.dec != '0) && (frac_sum <= MAX_TYPE_BITS);
                end
                TC_BYTES: begin
                    whole = bytes_bits;
                    ok = (bytes_bits != '0) && ({1'b0, bytes_bits} <= MAX_TYPE_BITS)
                        && (snap.dec == '0);
                end
                TC_STRING: begin
                    ok = (snap.whole == '0) && (snap.dec == '0);
                end
                default: begin
                end
            endcase
        end
    end

    assign bit_sum = {2'b00, whole} + {2'b00, snap.dec} + (NUM_WIDTH + 2)'(7);

    always_comb begin
        res_next.type_code    = snap.type_code;
        res_next.whole_bits   = whole;
        res_next.decimal_bits = snap.dec;
        res_next.list_length  = snap.len;
        res_next.is_list      = snap.is_list;
        res_next.is_dynamic   = (snap.type_code == TC_BYTES) || (snap.type_code == TC_STRING)
            || (snap.is_list && (snap.len == '0));
        res_next.total_bytes  = bit_sum[NUM_WIDTH+1:3];
        res_next.type_valid   = ok;
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        if (load) begin
            res_valid_next = snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_take) begin
            res_reg <= res_next;
        end
    end

    a_valid_has_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.type_valid) |-> (res_reg.type_code != TC_NONE))
        else $error("valid result without a type");

    a_address_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.type_valid && (res_reg.type_code == TC_ADDRESS))
        |-> (res_reg.whole_bits == ADDRESS_BITS))
        else $error("valid address not reported as 160 bits");

    a_bytes_dynamic: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && (res_reg.type_code == TC_BYTES)) |-> res_reg.is_dynamic)
        else $error("bytes result not marked dynamic");

endmodule

[design/abi_type_name_parser.sv]
// ----------------------------------------------------------------------------
// abi_type_name_parser
// Streaming parser for contract-parameter type names such as uint256,
// ufixed128x18, bytes32 or address[4].
// ----------------------------------------------------------------------------
// One character is accepted per cycle while s_tready is high, with s_tlast
// on the last character of a name. Each name gives exactly one result item
// after its last character is accepted, passing through the scanner's snapshot
// register and then the checker's result register. The parser restarts on the
// next character, so names can follow each other without gaps, and a waiting
// result does not stop the next name from being scanned.
module abi_type_name_parser
    import atnp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // character
    input  logic        s_tlast,   // final_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // type_code[3:0], whole_bits[19:4], decimal_bits[35:20], list_length[51:36],
    // is_list[52], is_dynamic[53], total_bytes[68:54], type_valid[69], zero fill
    output logic [71:0] m_tdata
);

    logic    snap_valid;
    logic    snap_take;
    snap_t   snap;
    result_t res;

    atnp_scanner u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (s_tvalid),
        .char_ready (s_tready),
        .char_data  (s_tdata),
        .char_last  (s_tlast),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .snap       (snap)
    );

    atnp_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .snap       (snap),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.type_valid, res.total_bytes, res.is_dynamic, res.is_list,
                      res.list_length, res.decimal_bits, res.whole_bits, res.type_code};

endmodule
